// ----- rtl/cqe_pkg.sv -----
// Shared types and constants for the circular queue engine.
// Holds the operation and status codes, the result item struct and the pointer helper.
// No dependencies.
package cqe_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned WORD_W = 32;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_LIST   = 2'd2,
    KIND_DUMP   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    status_e             status;
    logic [WORD_W-1:0]   data;
    logic                last;
  } cqe_res_t;

  function automatic ptr_t ptr_inc(ptr_t p);
    ptr_t r;
    r = (p == ptr_t'(DEPTH - 1)) ? '0 : p + ptr_t'(1);
    return r;
  endfunction

endpackage

// ----- rtl/cqe_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
module cqe_ram #(
  parameter int unsigned DEPTH_P = 16,
  parameter int unsigned WIDTH_P = 32
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [$clog2(DEPTH_P)-1:0] wr_addr_i,
  input  logic [WIDTH_P-1:0]         wr_data_i,
  input  logic                       rd_en_i,
  input  logic [$clog2(DEPTH_P)-1:0] rd_addr_i,
  output logic [WIDTH_P-1:0]         rd_data_o
);

  logic [WIDTH_P-1:0] mem_q [DEPTH_P];
  logic [WIDTH_P-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/cqe_out_buf.sv -----
// Two-entry output queue for result items; decouples the receiver stall from the core.
// Depends on cqe_pkg.
module cqe_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cqe_pkg::cqe_res_t push_item_i,
  input  logic              pop_i,
  output logic              valid_o,
  output cqe_pkg::cqe_res_t item_o,
  output logic [1:0]        cnt_o
);
  import cqe_pkg::*;

  cqe_res_t   ent_q [2];
  logic       rd_ptr_q, wr_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop = pop_i && (cnt_q != 2'd0);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_item_i;
    end
  end

  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = ent_q[rd_ptr_q];
  assign cnt_o   = cnt_q;

endmodule

// ----- rtl/circular_queue_engine_core.sv -----
// Top level of the circular queue engine: pointer control, slot RAM and output queue.
// Depends on cqe_pkg, cqe_ram and cqe_out_buf.
//
// Input channel (s_axis): one item is one operation. tuser carries the kind
// (insert, delete, list, dump); tdata carries the word to insert.
// Output channel (m_axis): tuser carries the status, tdata the word, tlast
// marks the final result of an operation.
// Insert and delete give one result each; a new item is accepted every
// cycle while the receiver keeps up.
// List gives one result per queued word (one empty result if the queue is empty) and
// dump gives DEPTH results; both walk the slot RAM at one read per cycle while the
// output queue has room, and hold tready low until the last read has been issued.
// A result passes the registered RAM read and then the output queue write
// before it shows as valid.
// Reset empties the queue, clears both pointers and marks every slot as
// never written, so unwritten slots read as zero; no clearing pass is run.
// When the receiver stalls, the two-entry output queue fills and tready
// drops; nothing is lost and no result is repeated.
module circular_queue_engine_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [cqe_pkg::WORD_W-1:0] s_axis_tdata,   // [31:0] data_in
  input  logic [1:0]                 s_axis_tuser,   // [1:0] kind
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [cqe_pkg::WORD_W-1:0] m_axis_tdata,   // [31:0] data_out
  output logic [1:0]                 m_axis_tuser,   // [1:0] status
  output logic                       m_axis_tlast
);
  import cqe_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LIST = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0]       state_q, state_d;
  ptr_t             head_q, head_d, tail_q, tail_d, idx_q, idx_d;
  logic             empty_q, empty_d;
  logic [DEPTH-1:0] valid_q, valid_d;

  logic             rd_vld_q, rd_last_q, rd_use_q;
  status_e          rd_status_q;

  logic             issue, iss_last, rd_en, wr_en, full, pop, can_issue;
  status_e          iss_status;
  ptr_t             rd_addr, wr_addr;
  kind_e            kind;
  logic [2:0]       occ;
  logic [1:0]       buf_cnt;
  logic             buf_valid;
  logic [WORD_W-1:0] ram_rdata;
  cqe_res_t         push_item, out_item;

  assign kind = kind_e'(s_axis_tuser);
  assign full = !empty_q && (ptr_inc(tail_q) == head_q);
  assign pop  = buf_valid && m_axis_tready;
  assign occ  = 3'(buf_cnt) + 3'(rd_vld_q);
  assign can_issue = pop ? (occ <= 3'd2) : (occ <= 3'd1);
  assign s_axis_tready = (state_q == S_IDLE) && can_issue;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    idx_d      = idx_q;
    empty_d    = empty_q;
    valid_d    = valid_q;
    issue      = 1'b0;
    iss_status = ST_OK;
    iss_last   = 1'b1;
    rd_en      = 1'b0;
    rd_addr    = idx_q;
    wr_en      = 1'b0;
    wr_addr    = tail_q;
    case (state_q)
      S_LIST: begin
        if (can_issue) begin
          issue    = 1'b1;
          rd_en    = 1'b1;
          iss_last = (idx_q == tail_q);
          idx_d    = ptr_inc(idx_q);
          if (iss_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_DUMP: begin
        if (can_issue) begin
          issue    = 1'b1;
          rd_en    = 1'b1;
          iss_last = (idx_q == '0);
          idx_d    = idx_q - ptr_t'(1);
          if (iss_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          issue = 1'b1;
          case (kind)
            KIND_INSERT: begin
              if (full) begin
                iss_status = ST_OVERFLOW;
              end else begin
                if (empty_q) begin
                  head_d  = '0;
                  tail_d  = '0;
                end else begin
                  tail_d  = ptr_inc(tail_q);
                end
                empty_d  = 1'b0;
                wr_en    = 1'b1;
                wr_addr  = tail_d;
                valid_d[wr_addr] = 1'b1;
              end
            end
            KIND_DELETE: begin
              if (empty_q) begin
                iss_status = ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = head_q;
                if (head_q == tail_q) begin
                  empty_d = 1'b1;
                  head_d  = '0;
                  tail_d  = '0;
                end else begin
                  head_d  = ptr_inc(head_q);
                end
              end
            end
            KIND_LIST: begin
              if (empty_q) begin
                iss_status = ST_EMPTY;
              end else begin
                rd_en    = 1'b1;
                rd_addr  = head_q;
                iss_last = (head_q == tail_q);
                if (!iss_last) begin
                  state_d = S_LIST;
                  idx_d   = ptr_inc(head_q);
                end
              end
            end
            KIND_DUMP: begin
              rd_en    = 1'b1;
              rd_addr  = ptr_t'(DEPTH - 1);
              iss_last = 1'b0;
              state_d  = S_DUMP;
              idx_d    = ptr_t'(DEPTH - 2);
            end
            default: begin
              iss_status = ST_OK;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      idx_q    <= '0;
      empty_q  <= 1'b1;
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      idx_q    <= idx_d;
      empty_q  <= empty_d;
      valid_q  <= valid_d;
      rd_vld_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_status_q <= iss_status;
      rd_last_q   <= iss_last;
      rd_use_q    <= rd_en && valid_q[rd_addr];
    end
  end

  cqe_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (WORD_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (s_axis_tdata),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (ram_rdata)
  );

  always_comb begin
    push_item.status = rd_status_q;
    push_item.data   = rd_use_q ? ram_rdata : '0;
    push_item.last   = rd_last_q;
  end

  cqe_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (rd_vld_q),
    .push_item_i (push_item),
    .pop_i       (m_axis_tready),
    .valid_o     (buf_valid),
    .item_o      (out_item),
    .cnt_o       (buf_cnt)
  );

  assign m_axis_tvalid = buf_valid;
  assign m_axis_tdata  = out_item.data;
  assign m_axis_tuser  = out_item.status;
  assign m_axis_tlast  = out_item.last;

endmodule

// ----- rtl/cqe_chk.sv -----
// Port-level checker for circular_queue_engine_core, attached by bind.
// Depends on cqe_pkg.
module cqe_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [cqe_pkg::WORD_W-1:0] m_axis_tdata,
  input logic [1:0]                 m_axis_tuser,
  input logic                       m_axis_tlast
);
  import cqe_pkg::*;

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result item changed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == ST_OK) || (m_axis_tuser == ST_OVERFLOW)
                      || (m_axis_tuser == ST_EMPTY))
    else $error("bad status code");

  a_err_zero_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0) && m_axis_tlast)
    else $error("error result without zero word or last mark");

endmodule

bind circular_queue_engine_core cqe_chk u_cqe_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
